>>> hdl/qdpv_pkg.sv
// ----------------------------------------------------------------------------
// qdpv_pkg
// Shared types and constants for the quadrature decoder with period velocity.
// ----------------------------------------------------------------------------
package qdpv_pkg;

    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_TIME_WIDTH  = 48;
    localparam int QUOT_WIDTH      = 32;
    localparam int ADDR_WIDTH      = 3;

    localparam logic [1:0] MODE_EDGE_A = 2'd0;
    localparam logic [1:0] MODE_EDGE_B = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic REG_SCALE   = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic [31:0] SCALE_RESET   = 32'd1;
    localparam logic [31:0] TIMEOUT_RESET = 32'd100000;
    localparam logic [31:0] VEL_MAX       = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic        pin_level;
        logic [47:0] time_us;
    } item_t;

    typedef struct packed {
        logic signed [31:0] position_count;
        logic signed [31:0] angular_velocity;
        logic               stopped;
    } result_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic res_free;
    } stat_t;

endpackage

>>> hdl/qdpv_div.sv
// ----------------------------------------------------------------------------
// qdpv_div
// Restoring divider, one quotient bit per cycle, unsigned 32-bit dividend.
// ----------------------------------------------------------------------------
module qdpv_div
    import qdpv_pkg::*;
#(
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [QUOT_WIDTH-1:0]   dividend,
    input  logic [TIME_WIDTH-1:0]   divisor,
    output logic                    done,
    output logic [QUOT_WIDTH-1:0]   quotient
);

    localparam int RW    = ((TIME_WIDTH > QUOT_WIDTH) ? TIME_WIDTH : QUOT_WIDTH) + 1;
    localparam int CNT_W = $clog2(QUOT_WIDTH + 1);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic [RW-1:0]         rem_reg,   rem_next;
    logic [QUOT_WIDTH-1:0] quo_reg,   quo_next;
    logic [RW-1:0]         trial;
    logic [RW-1:0]         dsr;

    assign dsr   = RW'(divisor);
    assign trial = {rem_reg[RW-2:0], quo_reg[QUOT_WIDTH-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUOT_WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= dsr)
            begin
                rem_next = trial - dsr;
                quo_next = {quo_reg[QUOT_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[QUOT_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/qdpv_dp.sv
// ----------------------------------------------------------------------------
// qdpv_dp
// Datapath: pin levels, count, edge time, velocity, divider, result register.
// ----------------------------------------------------------------------------
module qdpv_dp
    import qdpv_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  item_t       item,
    input  logic [31:0] velocity_scale,
    input  logic [31:0] stop_timeout_us,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam int CMPW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    logic                   level_a_reg,   level_a_next;
    logic                   level_b_reg,   level_b_next;
    logic [COUNT_WIDTH-1:0] count_reg,     count_next;
    logic [TIME_WIDTH-1:0]  last_edge_reg, last_edge_next;
    logic [31:0]            vel_reg,       vel_next;
    logic                   valid_reg,     valid_next;
    logic                   is_edge_reg;
    logic                   up_reg;
    logic                   zero_int_reg;
    logic [TIME_WIDTH-1:0]  elapsed_reg;
    result_t                res_reg;

    logic [TIME_WIDTH-1:0]  now;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic                   is_edge;
    logic                   up;
    logic                   div_done;
    logic [QUOT_WIDTH-1:0]  quot;
    logic [31:0]            mag;
    logic                   timed_out;
    logic [63:0]            count_ext;

    assign now     = TIME_WIDTH'(item.time_us);
    assign elapsed = now - last_edge_reg;
    assign is_edge = (item.mode == MODE_EDGE_A) || (item.mode == MODE_EDGE_B);
    assign up      = (item.mode == MODE_EDGE_A) ? (item.pin_level != level_b_reg)
                                                : (level_a_reg == item.pin_level);

    qdpv_div #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (velocity_scale),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign mag       = (zero_int_reg || quot[QUOT_WIDTH-1]) ? VEL_MAX : 32'(quot);
    assign timed_out = CMPW'(elapsed_reg) >= CMPW'(stop_timeout_us);
    assign count_ext = 64'(count_next);

    always_comb
    begin
        level_a_next   = level_a_reg;
        level_b_next   = level_b_reg;
        count_next     = count_reg;
        last_edge_next = last_edge_reg;
        vel_next       = vel_reg;
        valid_next     = valid_reg;
        if (cmd.load && is_edge)
        begin
            if (item.mode == MODE_EDGE_A)
                level_a_next = item.pin_level;
            else
                level_b_next = item.pin_level;
            if (up)
                count_next = count_reg + COUNT_WIDTH'(1);
            else
                count_next = count_reg - COUNT_WIDTH'(1);
            last_edge_next = now;
        end
        if (cmd.finish)
        begin
            if (is_edge_reg)
                vel_next = up_reg ? mag : (32'd0 - mag);
            else if (timed_out)
                vel_next = '0;
        end
        if (result_valid && !result_stall)
            valid_next = 1'b0;
        if (cmd.finish)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_a_reg   <= 1'b0;
            level_b_reg   <= 1'b0;
            count_reg     <= '0;
            last_edge_reg <= '0;
            vel_reg       <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            level_a_reg   <= level_a_next;
            level_b_reg   <= level_b_next;
            count_reg     <= count_next;
            last_edge_reg <= last_edge_next;
            vel_reg       <= vel_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_edge_reg  <= is_edge;
            up_reg       <= up;
            zero_int_reg <= (elapsed == '0);
            elapsed_reg  <= elapsed;
        end
        if (cmd.finish)
        begin
            res_reg.position_count   <= count_ext[31:0];
            res_reg.angular_velocity <= vel_next;
            res_reg.stopped          <= !is_edge_reg && timed_out;
        end
    end

    assign stat.need_div = is_edge && (elapsed != '0);
    assign stat.div_done = div_done;
    assign stat.res_free = !valid_reg || !result_stall;

    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

>>> hdl/qdpv_ctrl.sv
// ----------------------------------------------------------------------------
// qdpv_ctrl
// Sequencer: takes an item, runs the divider for timed edges, posts result.
// ----------------------------------------------------------------------------
module qdpv_ctrl
    import qdpv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.need_div ? S_DIV_GO : S_FINISH;
                end
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.res_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

>>> hdl/quadrature_decoder_period_velocity.sv
// Sequence: an edge with a nonzero interval runs S_DIV_GO, the 32-step serial
//   divider, S_DIV_WAIT and S_FINISH before result_valid rises; a tick or a
//   zero-interval edge goes straight to S_FINISH, which waits on result_stall.
// Items: one at a time; item_stall stays high until the sequencer is idle.
// Reset: rst_n clears levels, count, edge time and velocity; scale resets
//   to 1 and stop timeout to 100000 us.
// ----------------------------------------------------------------------------
// quadrature_decoder_period_velocity
// x4 quadrature decoder with period-based velocity and stop timeout.
// ----------------------------------------------------------------------------
module quadrature_decoder_period_velocity
    import qdpv_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    logic [31:0] scale_reg,   scale_next;
    logic [31:0] timeout_reg, timeout_next;
    logic        wr_en;
    cmd_t        cmd;
    stat_t       stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        scale_next   = scale_reg;
        timeout_next = timeout_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_SCALE:   scale_next   = pwdata;
                REG_TIMEOUT: timeout_next = pwdata;
                default:     scale_next   = scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= SCALE_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            scale_reg   <= scale_next;
            timeout_reg <= timeout_next;
        end
    end

    assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_reg : scale_reg;

    qdpv_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    qdpv_dp #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .item            (item),
        .velocity_scale  (scale_reg),
        .stop_timeout_us (timeout_reg),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result)
    );

endmodule
